/* sv/qalu_pkg.sv */
// Shared types, codes, constants and helpers for the quaternion ALU.
// No dependencies; the top level, the CORDIC cell and the checker import this package.
`default_nettype none

package qalu_pkg;

    // Default widths and depths
    localparam int FRAC_BITS_DEF   = 28;
    localparam int ITER_STAGES_DEF = 24;

    // Operation codes
    localparam logic [1:0] ACT_MUL  = 2'd0;
    localparam logic [1:0] ACT_CONJ = 2'd1;
    localparam logic [1:0] ACT_NORM = 2'd2;
    localparam logic [1:0] ACT_ROT  = 2'd3;

    // Fault codes
    localparam logic [1:0] FLT_OK   = 2'd0;
    localparam logic [1:0] FLT_ZERO = 2'd1;
    localparam logic [1:0] FLT_SAT  = 2'd2;

    // CORDIC datapath width (Q30 values with headroom)
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    // Angle constants in Q31
    localparam logic signed [35:0] PI_Q31      = 36'sd6746518852;
    localparam logic signed [35:0] TWO_PI_Q31  = 36'sd13493037705;
    localparam logic signed [35:0] HALF_PI_Q31 = 36'sd3373259426;

    // Reciprocal of TWO_PI_Q31, scaled by 2^RECIP_SH, for the range reduction
    localparam int RECIP_SH = 48;
    localparam logic [15:0] RECIP = 16'((64'd1 << RECIP_SH) / 64'd13493037705);

    // Arctangent table in Q30
    localparam logic [31:0] ATAN_Q30 [30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic        [1:0]  action;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] angle;
    } qalu_cmd_t;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic        [1:0]  fault;
    } qalu_res_t;

    // Per-item data that travels alongside the cell chains
    typedef struct packed {
        logic [1:0]       action;
        logic [3:0][31:0] a;
        logic [3:0][31:0] res;
        logic             sat;
        logic             zero;
        logic             big;
    } qalu_side_t;

    // Clamp to 32 bits; bit 32 flags a clamp
    function automatic logic [32:0] sat32(input logic signed [69:0] v);
        logic [32:0] r;
        if (v > 70'sd2147483647)
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else if (v < -70'sd2147483648)
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/quaternion_alu.sv */
// Quaternion ALU top level: multiply, conjugate, normalize, axis-angle rotation.
// Depends on qalu_pkg, qalu_sqrt_cell, qalu_div_cell and qalu_cordic_cell.
//
//   channel   | signals            | transfer
//   ----------+--------------------+-----------------------------------
//   command   | start, busy, cmd   | edge with start high and busy low
//   result    | done, result       | edge ending the cycle done is high
//
// Every operation has the same latency, and a new command is taken every
// cycle. The latency is set by the 32-cell square-root chain and the
// FRAC_BITS+1 cell divider chain of the normalize path; the other operations
// are delayed to match. busy is always low. Reset clears only the valid line;
// the result side cannot stall.
`default_nettype none

module quaternion_alu #(
    parameter int FRAC_BITS        = qalu_pkg::FRAC_BITS_DEF,
    parameter int ITERATION_STAGES = qalu_pkg::ITER_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  qalu_pkg::qalu_cmd_t cmd,
    output logic                done,
    output qalu_pkg::qalu_res_t result
);
    import qalu_pkg::*;

    localparam int QB       = FRAC_BITS + 1;
    localparam int SQ_STEPS = 32;
    localparam int SQ_LAST  = 2 + SQ_STEPS;
    localparam int DV_PREP  = SQ_LAST + 1;
    localparam int LASTS    = DV_PREP + QB;
    localparam int RIDX     = 8 + ITERATION_STAGES;
    localparam int SHR      = 30 - FRAC_BITS;
    localparam logic signed [65:0] MUL_RND = (66'sd1 <<< FRAC_BITS) >>> 1;
    localparam logic signed [CW-1:0] W_RND = (34'sd1 <<< SHR) >>> 1;

    // Valid line
    logic [LASTS:1] vld_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[LASTS-1:1], start};
            done_reg <= vld_reg[LASTS];
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;

    // Stage 1: all products, half angle in Q31 plus pi
    logic signed [31:0] av [4];
    logic signed [31:0] bv [4];
    logic signed [46:0] h_in;

    always_comb
    begin
        av[0] = cmd.a_w;
        av[1] = cmd.a_x;
        av[2] = cmd.a_y;
        av[3] = cmd.a_z;
        if (cmd.action == ACT_NORM)
        begin
            bv = av;
        end
        else
        begin
            bv[0] = cmd.b_w;
            bv[1] = cmd.b_x;
            bv[2] = cmd.b_y;
            bv[3] = cmd.b_z;
        end
        h_in = 47'(cmd.angle) <<< SHR;
    end

    logic [1:0]         act1_reg;
    logic signed [31:0] a1_reg [4];
    logic signed [63:0] prod1_reg [4][4];
    logic signed [46:0] t1_reg;

    always_ff @(posedge clk)
    begin
        act1_reg <= cmd.action;
        t1_reg   <= h_in + 47'(PI_Q31);
        for (int i = 0; i < 4; i++)
        begin
            a1_reg[i] <= av[i];
            for (int j = 0; j < 4; j++)
            begin
                prod1_reg[i][j] <= av[i] * bv[j];
            end
        end
    end

    // Stage 2: product sums, sum of squares, reciprocal multiply
    logic [1:0]         act2_reg;
    logic signed [31:0] a2_reg [4];
    logic signed [65:0] sum2_reg [4];
    logic [64:0]        sq2_reg;
    logic signed [46:0] t2_reg;
    logic signed [63:0] tm2_reg;

    always_ff @(posedge clk)
    begin
        act2_reg <= act1_reg;
        a2_reg   <= a1_reg;
        sum2_reg[0] <= 66'(prod1_reg[0][0]) - 66'(prod1_reg[1][1])
                     - 66'(prod1_reg[2][2]) - 66'(prod1_reg[3][3]);
        sum2_reg[1] <= 66'(prod1_reg[0][1]) + 66'(prod1_reg[1][0])
                     + 66'(prod1_reg[2][3]) - 66'(prod1_reg[3][2]);
        sum2_reg[2] <= 66'(prod1_reg[0][2]) - 66'(prod1_reg[1][3])
                     + 66'(prod1_reg[2][0]) + 66'(prod1_reg[3][1]);
        sum2_reg[3] <= 66'(prod1_reg[0][3]) + 66'(prod1_reg[1][2])
                     - 66'(prod1_reg[2][1]) + 66'(prod1_reg[3][0]);
        sq2_reg <= 65'($unsigned(prod1_reg[0][0])) + 65'($unsigned(prod1_reg[1][1]))
                 + 65'($unsigned(prod1_reg[2][2])) + 65'($unsigned(prod1_reg[3][3]));
        t2_reg  <= t1_reg;
        tm2_reg <= t1_reg * $signed({1'b0, RECIP});
    end

    // Stage 3: multiply and conjugate results enter the side line
    qalu_side_t         side3_next;
    logic signed [65:0] mrnd [4];
    logic [32:0]        sv3 [4];

    always_comb
    begin
        side3_next.action = act2_reg;
        side3_next.zero   = (act2_reg == ACT_NORM) && (sq2_reg == '0);
        side3_next.big    = sq2_reg[64];
        side3_next.sat    = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            side3_next.a[i]   = a2_reg[i];
            side3_next.res[i] = '0;
            mrnd[i]           = (sum2_reg[i] + MUL_RND) >>> FRAC_BITS;
            sv3[i]            = sat32(70'(mrnd[i]));
        end
        case (act2_reg)
            ACT_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    side3_next.res[i] = sv3[i][31:0];
                end
                side3_next.sat = sv3[0][32] | sv3[1][32] | sv3[2][32] | sv3[3][32];
            end
            ACT_CONJ:
            begin
                side3_next.res[0] = a2_reg[0];
                for (int i = 1; i < 4; i++)
                begin
                    if (a2_reg[i] == 32'sh80000000)
                    begin
                        side3_next.res[i] = 32'h7FFFFFFF;
                        side3_next.sat    = 1'b1;
                    end
                    else
                    begin
                        side3_next.res[i] = -a2_reg[i];
                    end
                end
            end
            default:
            begin
                side3_next.sat = 1'b0;
            end
        endcase
    end

    // Rotation: range reduction
    logic signed [15:0]  k0;
    logic signed [51:0]  kt;
    logic signed [51:0]  rr;
    logic signed [36:0]  rr3_reg;
    logic signed [36:0]  hr_c;
    logic signed [35:0]  hr4_reg;
    logic signed [35:0]  hf;
    logic signed [35:0]  hz;
    logic                neg_c;
    logic signed [CW-1:0] z5_reg;
    logic                neg5_reg;

    always_comb
    begin
        k0 = tm2_reg[63:48];
        kt = k0 * TWO_PI_Q31;
        rr = 52'(t2_reg) - kt;
        if (rr3_reg < 0)
        begin
            hr_c = rr3_reg + 37'(TWO_PI_Q31) - 37'(PI_Q31);
        end
        else if (rr3_reg >= 37'(TWO_PI_Q31))
        begin
            hr_c = rr3_reg - 37'(TWO_PI_Q31) - 37'(PI_Q31);
        end
        else
        begin
            hr_c = rr3_reg - 37'(PI_Q31);
        end
        // Fold into the right half plane
        neg_c = 1'b1;
        if (hr4_reg > HALF_PI_Q31)
        begin
            hf = hr4_reg - PI_Q31;
        end
        else if (hr4_reg < -HALF_PI_Q31)
        begin
            hf = hr4_reg + PI_Q31;
        end
        else
        begin
            hf    = hr4_reg;
            neg_c = 1'b0;
        end
        hz = (hf + 36'sd1) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        rr3_reg  <= rr[36:0];
        hr4_reg  <= hr_c[35:0];
        z5_reg   <= hz[CW-1:0];
        neg5_reg <= neg_c;
    end

    // Rotation: CORDIC chain
    logic signed [CW-1:0] cx_w [ITERATION_STAGES+1];
    logic signed [CW-1:0] cy_w [ITERATION_STAGES+1];
    logic signed [CW-1:0] cz_w [ITERATION_STAGES+1];
    logic                 cn_w [ITERATION_STAGES+1];

    assign cx_w[0] = CORDIC_GAIN;
    assign cy_w[0] = '0;
    assign cz_w[0] = z5_reg;
    assign cn_w[0] = neg5_reg;

    for (genvar g = 0; g < ITERATION_STAGES; g++)
    begin : g_cordic
        qalu_cordic_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .x_in    (cx_w[g]),
            .y_in    (cy_w[g]),
            .z_in    (cz_w[g]),
            .neg_in  (cn_w[g]),
            .x_out   (cx_w[g+1]),
            .y_out   (cy_w[g+1]),
            .z_out   (cz_w[g+1]),
            .neg_out (cn_w[g+1])
        );
    end

    // Rotation: sign, cosine rounding, sine times axis
    qalu_side_t           side_reg [LASTS:3];
    logic signed [CW-1:0] xf;
    logic signed [CW-1:0] yf;
    logic signed [CW-1:0] w6_reg;
    logic signed [CW-1:0] yf6_reg;
    logic signed [CW-1:0] w7_reg;
    logic signed [65:0]   rp7_reg [3];

    always_comb
    begin
        xf = cn_w[ITERATION_STAGES] ? -cx_w[ITERATION_STAGES] : cx_w[ITERATION_STAGES];
        yf = cn_w[ITERATION_STAGES] ? -cy_w[ITERATION_STAGES] : cy_w[ITERATION_STAGES];
    end

    always_ff @(posedge clk)
    begin
        w6_reg  <= (xf + W_RND) >>> SHR;
        yf6_reg <= yf;
        w7_reg  <= w6_reg;
        for (int i = 0; i < 3; i++)
        begin
            rp7_reg[i] <= yf6_reg * $signed(side_reg[6+ITERATION_STAGES].a[i+1]);
        end
    end

    // Side line, with rotation results merged in
    qalu_side_t         side_rot;
    logic signed [65:0] rr7 [3];
    logic [32:0]        svw;
    logic [32:0]        svr [3];

    always_comb
    begin
        side_rot = side_reg[RIDX-1];
        svw      = sat32(70'(w7_reg));
        for (int i = 0; i < 3; i++)
        begin
            rr7[i] = (rp7_reg[i] + 66'sd536870912) >>> 30;
            svr[i] = sat32(70'(rr7[i]));
        end
        if (side_reg[RIDX-1].action == ACT_ROT)
        begin
            side_rot.res[0] = svw[31:0];
            for (int i = 0; i < 3; i++)
            begin
                side_rot.res[i+1] = svr[i][31:0];
            end
            side_rot.sat = svw[32] | svr[0][32] | svr[1][32] | svr[2][32];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[3] <= side3_next;
        for (int n = 4; n <= LASTS; n++)
        begin
            side_reg[n] <= (n == RIDX) ? side_rot : side_reg[n-1];
        end
    end

    // Normalize: square-root chain
    logic [63:0] sq_rem_w  [SQ_STEPS+1];
    logic [63:0] sq_root_w [SQ_STEPS+1];

    assign sq_rem_w[0]  = sq2_reg[63:0];
    assign sq_root_w[0] = '0;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        qalu_sqrt_cell #(.STEP(g)) u_cell (
            .clk      (clk),
            .rem_in   (sq_rem_w[g]),
            .root_in  (sq_root_w[g]),
            .rem_out  (sq_rem_w[g+1]),
            .root_out (sq_root_w[g+1])
        );
    end

    // Normalize: dividends and divisor
    logic [32:0]         len_c;
    logic [31:0]         mag_c [4];
    logic signed [31:0]  ap_c  [4];
    logic [32:0]         den_p_reg;
    logic [3:0][63:0]    num_p_reg;

    always_comb
    begin
        len_c = side_reg[SQ_LAST].big ? 33'h100000000 : {1'b0, sq_root_w[SQ_STEPS][31:0]};
        for (int i = 0; i < 4; i++)
        begin
            ap_c[i]  = $signed(side_reg[SQ_LAST].a[i]);
            mag_c[i] = (ap_c[i] < 0) ? 32'(-ap_c[i]) : ap_c[i];
        end
    end

    always_ff @(posedge clk)
    begin
        den_p_reg <= side_reg[SQ_LAST].zero ? 33'd1 : len_c;
        for (int i = 0; i < 4; i++)
        begin
            num_p_reg[i] <= (64'(mag_c[i]) << FRAC_BITS) + 64'(len_c >> 1);
        end
    end

    // Normalize: divider chain, most significant quotient bit first
    logic [32:0]        dv_den_w [QB+1];
    logic [3:0][63:0]   dv_rem_w [QB+1];
    logic [3:0][QB-1:0] dv_quo_w [QB+1];

    assign dv_den_w[0] = den_p_reg;
    assign dv_rem_w[0] = num_p_reg;
    assign dv_quo_w[0] = '0;

    for (genvar g = 0; g < QB; g++)
    begin : g_div
        qalu_div_cell #(.QB(QB), .BITPOS(QB - 1 - g)) u_cell (
            .clk     (clk),
            .den_in  (dv_den_w[g]),
            .rem_in  (dv_rem_w[g]),
            .quo_in  (dv_quo_w[g]),
            .den_out (dv_den_w[g+1]),
            .rem_out (dv_rem_w[g+1]),
            .quo_out (dv_quo_w[g+1])
        );
    end

    // Output register: pick the result and fault code
    qalu_res_t          res_next;
    qalu_res_t          res_reg;
    logic [31:0]        nq [4];
    logic [31:0]        ro [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nq[i] = 32'(dv_quo_w[QB][i]);
            ro[i] = side_reg[LASTS].res[i];
        end
        res_next.fault = side_reg[LASTS].sat ? FLT_SAT : FLT_OK;
        if (side_reg[LASTS].action == ACT_NORM)
        begin
            res_next.fault = FLT_OK;
            for (int i = 0; i < 4; i++)
            begin
                ro[i] = side_reg[LASTS].a[i][31] ? -nq[i] : nq[i];
                if (side_reg[LASTS].zero)
                begin
                    ro[i] = '0;
                end
            end
            if (side_reg[LASTS].zero)
            begin
                res_next.fault = FLT_ZERO;
            end
        end
        res_next.r_w = ro[0];
        res_next.r_x = ro[1];
        res_next.r_y = ro[2];
        res_next.r_z = ro[3];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

/* sv/qalu_sqrt_cell.sv */
// One restoring square-root cell: settles one root bit per clock.
// Depends on nothing but the clock; chained 32 deep in the top level.
`default_nettype none

module qalu_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        clk,
    input  logic [63:0] rem_in,
    input  logic [63:0] root_in,
    output logic [63:0] rem_out,
    output logic [63:0] root_out
);
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic        fits;
    logic [63:0] rem_next;
    logic [63:0] root_next;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;

    // Try the next root bit against the remainder
    always_comb
    begin
        trial = root_in + SQ_BIT;
        fits  = (rem_in >= trial);
        if (fits)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + SQ_BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    // Advance to the neighbor
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

/* sv/qalu_div_cell.sv */
// One restoring divider cell for four lanes sharing a divisor.
// Settles quotient bit BITPOS per clock; chained in the top level.
`default_nettype none

module qalu_div_cell #(
    parameter int QB     = 29,
    parameter int BITPOS = 0
) (
    input  logic                  clk,
    input  logic [32:0]           den_in,
    input  logic [3:0][63:0]      rem_in,
    input  logic [3:0][QB-1:0]    quo_in,
    output logic [32:0]           den_out,
    output logic [3:0][63:0]      rem_out,
    output logic [3:0][QB-1:0]    quo_out
);
    logic [63:0]          dsh;
    logic [3:0][63:0]     rem_next;
    logic [3:0][QB-1:0]   quo_next;
    logic [32:0]          den_reg;
    logic [3:0][63:0]     rem_reg;
    logic [3:0][QB-1:0]   quo_reg;

    // Subtract the shifted divisor where it fits
    always_comb
    begin
        dsh = 64'(den_in) << BITPOS;
        for (int i = 0; i < 4; i++)
        begin
            quo_next[i] = quo_in[i];
            if (rem_in[i] >= dsh)
            begin
                rem_next[i]         = rem_in[i] - dsh;
                quo_next[i][BITPOS] = 1'b1;
            end
            else
            begin
                rem_next[i]         = rem_in[i];
                quo_next[i][BITPOS] = 1'b0;
            end
        end
    end

    // Advance to the neighbor
    always_ff @(posedge clk)
    begin
        den_reg <= den_in;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

`default_nettype wire

/* sv/qalu_cordic_cell.sv */
// One rotation-mode CORDIC cell: one micro-rotation per clock.
// Depends on qalu_pkg for the datapath width and arctangent table.
`default_nettype none

module qalu_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                              clk,
    input  logic signed [qalu_pkg::CW-1:0]    x_in,
    input  logic signed [qalu_pkg::CW-1:0]    y_in,
    input  logic signed [qalu_pkg::CW-1:0]    z_in,
    input  logic                              neg_in,
    output logic signed [qalu_pkg::CW-1:0]    x_out,
    output logic signed [qalu_pkg::CW-1:0]    y_out,
    output logic signed [qalu_pkg::CW-1:0]    z_out,
    output logic                              neg_out
);
    import qalu_pkg::*;

    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_Q30[STEP]);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic                 neg_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    // Advance to the neighbor
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_in;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign neg_out = neg_reg;

endmodule

`default_nettype wire

/* sv/qalu_checker.sv */
// Port-level checks on the quaternion ALU, attached by the bind at the end.
// Depends on qalu_pkg and the port list of quaternion_alu.
`default_nettype none

module qalu_checker #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input qalu_pkg::qalu_cmd_t cmd,
    input logic                done,
    input qalu_pkg::qalu_res_t result
);
    import qalu_pkg::*;

    localparam int LAT = FRAC_BITS + 37;

    // Every transfer in yields a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after fixed latency");

    // No result without a command
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result without a command");

    // Conjugate passes the scalar part through
    a_conj_w: assert property (@(posedge clk) disable iff (!rst_n)
        (start && cmd.action == ACT_CONJ) |-> ##LAT (result.r_w == $past(cmd.a_w, LAT)))
        else $error("conjugate scalar part altered");

    // Zero quaternion normalize flags the fault
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && cmd.action == ACT_NORM && cmd.a_w == 0 && cmd.a_x == 0
         && cmd.a_y == 0 && cmd.a_z == 0) |-> ##LAT (result.fault == FLT_ZERO))
        else $error("zero-length normalize not flagged");

    // Zero-length fault returns zeros
    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fault == FLT_ZERO) |->
        (result.r_w == 0 && result.r_x == 0 && result.r_y == 0 && result.r_z == 0))
        else $error("zero-length normalize returned nonzero data");

endmodule

bind quaternion_alu qalu_checker #(.FRAC_BITS(FRAC_BITS)) u_qalu_checker (.*);

`default_nettype wire
